// ===== design/priority_multi_chance_fifo_evictor_assert.svh =====
// assertion macros for the multi-chance fifo evictor
`ifndef PRIORITY_MULTI_CHANCE_FIFO_EVICTOR_ASSERT_SVH
`define PRIORITY_MULTI_CHANCE_FIFO_EVICTOR_ASSERT_SVH

// condition holds at every edge out of reset
`define PMCFE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pmcfe assertion failed");

// consequent holds in the cycle after the antecedent
`define PMCFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pmcfe assertion failed");

`endif

// ===== design/pmcfe_pkg.sv =====
// shared types and constants of the multi-chance fifo evictor
package pmcfe_pkg;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned OWNER_W   = 22;
  localparam int unsigned CHANCE_W  = 8;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned SPENT_W   = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [SPENT_W-1:0] SPENT_MAX = 4'd15;

  typedef enum logic [MODE_W-1:0] {
    MODE_ACTIVATE = 2'd0,
    MODE_USED     = 2'd1,
    MODE_EVICT    = 2'd2
  } mode_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_DONE   = 2'd0,
    OUT_VICTIM = 2'd1,
    OUT_EMPTY  = 2'd2,
    OUT_LIMIT  = 2'd3
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRIO_OWNER = 3'd0,
    CFG_LOW_OWNER  = 3'd1,
    CFG_PRIO_CH    = 3'd2,
    CFG_LOW_CH     = 3'd3,
    CFG_DEF_CH     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                tracked;
    logic [CHANCE_W-1:0] rem_chances;
    logic [CHANCE_W-1:0] init_chances;
  } entry_t;

endpackage

// ===== design/pmcfe_if.sv =====
// valid/ready channel interfaces for request and result words
interface pmcfe_in_if import pmcfe_pkg::*;;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [IDX_W-1:0]   entry_index;
  logic [OWNER_W-1:0] owner_id;

  modport source (output valid, output mode, output entry_index, output owner_id,
                  input ready);
  modport sink   (input valid, input mode, input entry_index, input owner_id,
                  output ready);
endinterface

interface pmcfe_out_if import pmcfe_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [IDX_W-1:0]     victim_index;
  logic [SPENT_W-1:0]   chances_spent;

  modport source (output valid, output outcome, output victim_index,
                  output chances_spent, input ready);
  modport sink   (input valid, input outcome, input victim_index,
                  input chances_spent, output ready);
endinterface

// ===== design/pmcfe_ram.sv =====
// generic single-write, single-read ram with registered read data
module pmcfe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/pmcfe_cfg.sv =====
// configuration registers and owner to chance budget lookup
module pmcfe_cfg import pmcfe_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [OWNER_W-1:0]   cfg_data_i,
  input  logic [OWNER_W-1:0]   owner_i,
  output logic [CHANCE_W-1:0]  budget_o
);

  logic [OWNER_W-1:0]  prio_owner_q;
  logic [OWNER_W-1:0]  low_owner_q;
  logic [CHANCE_W-1:0] prio_ch_q;
  logic [CHANCE_W-1:0] low_ch_q;
  logic [CHANCE_W-1:0] def_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_owner_q <= '0;
      low_owner_q  <= '0;
      prio_ch_q    <= '0;
      low_ch_q     <= '0;
      def_ch_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PRIO_OWNER: prio_owner_q <= cfg_data_i;
        CFG_LOW_OWNER:  low_owner_q  <= cfg_data_i;
        CFG_PRIO_CH:    prio_ch_q    <= cfg_data_i[CHANCE_W-1:0];
        CFG_LOW_CH:     low_ch_q     <= cfg_data_i[CHANCE_W-1:0];
        CFG_DEF_CH:     def_ch_q     <= cfg_data_i[CHANCE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (prio_owner_q != '0 && owner_i == prio_owner_q) begin
      budget_o = prio_ch_q;
    end else if (low_owner_q != '0 && owner_i == low_owner_q) begin
      budget_o = low_ch_q;
    end else begin
      budget_o = def_ch_q;
    end
  end

endmodule

// ===== design/priority_multi_chance_fifo_evictor.sv =====
// top level of the multi-chance fifo evictor: control sequencer and state memories
//
// Entries wait in a fifo ring memory; a second memory holds each entry's tracked
// flag and its remaining and initial chance counts. One word is handled at a time.
// Activate and used words pass from acceptance through the chance store read to
// the result register. An evict word on an empty queue goes straight from
// acceptance to the result; otherwise each head examined takes a ring read feeding
// the chance store read, then the read-modify-write, until the scan ends on a
// victim or reaches SCAN_LIMIT rotated heads. The result is held in an output
// register, and a new word is taken while it waits; the next result waits in the
// sequencer until that register frees. After reset a clearing pass sweeps every
// address of the chance store; no word is accepted during it, configuration
// writes are taken as ever.
`include "priority_multi_chance_fifo_evictor_assert.svh"

module priority_multi_chance_fifo_evictor import pmcfe_pkg::*; #(
  parameter int unsigned ENTRIES    = 1024,
  parameter int unsigned SCAN_LIMIT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [OWNER_W-1:0]   cfg_data_i,
  pmcfe_in_if.sink             in_i,
  pmcfe_out_if.source          out_o
);

  localparam int unsigned AW  = $clog2(ENTRIES);
  localparam int unsigned CW  = AW + 1;
  localparam int unsigned ITW = $clog2(SCAN_LIMIT + 1);
  localparam int unsigned EW  = $bits(entry_t);

  localparam logic [AW-1:0]  LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [CW-1:0]  CNT_FULL  = CW'(ENTRIES);
  localparam logic [ITW-1:0] ITER_END  = ITW'(SCAN_LIMIT);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP,
    ST_EV_ENT,
    ST_EV_CHK,
    ST_RESP
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        clr_q;
  logic [AW-1:0]        head_q;
  logic [AW-1:0]        tail_q;
  logic [CW-1:0]        count_q;
  logic [ITW-1:0]       iter_q;
  logic [SPENT_W-1:0]   spent_q;
  logic                 fwd_q;
  logic [IDX_W-1:0]     h_q;
  logic [MODE_W-1:0]    mode_q;
  logic [IDX_W-1:0]     idx_q;
  logic [OWNER_W-1:0]   owner_q;
  logic                 idx_ok_q;
  logic [OUTCOME_W-1:0] res_outcome_q;
  logic [IDX_W-1:0]     res_victim_q;
  logic [SPENT_W-1:0]   res_spent_q;
  logic                 out_valid_q;
  logic [OUTCOME_W-1:0] out_outcome_q;
  logic [IDX_W-1:0]     out_victim_q;
  logic [SPENT_W-1:0]   out_spent_q;

  logic [31:0]         in_idx_ext;
  logic [31:0]         idx_ext;
  logic [31:0]         h_ext;
  logic [IDX_W-1:0]    h_sel;
  logic [31:0]         h_sel_ext;
  logic [AW-1:0]       head_nxt;
  logic [AW-1:0]       tail_nxt;
  logic [CHANCE_W-1:0] budget;
  logic                op_push;
  logic                op_restore;
  logic                rotate;
  logic                out_load;

  logic                ent_we;
  logic [AW-1:0]       ent_waddr;
  entry_t              ent_wdata;
  logic [AW-1:0]       ent_raddr;
  entry_t              ent_rd;
  logic [EW-1:0]       ent_rdata;
  logic                ring_we;
  logic [AW-1:0]       ring_waddr;
  logic [IDX_W-1:0]    ring_wdata;
  logic [AW-1:0]       ring_raddr;
  logic [IDX_W-1:0]    ring_rdata;

  pmcfe_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .owner_i    (owner_q),
    .budget_o   (budget)
  );

  pmcfe_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_ring (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .waddr_i(ring_waddr),
    .wdata_i(ring_wdata),
    .raddr_i(ring_raddr),
    .rdata_o(ring_rdata)
  );

  pmcfe_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  assign ent_rd     = entry_t'(ent_rdata);
  assign in_idx_ext = 32'(in_i.entry_index);
  assign idx_ext    = 32'(idx_q);
  assign h_ext      = 32'(h_q);
  // the slot written by a rotation can be the next head
  assign h_sel      = fwd_q ? h_q : ring_rdata;
  assign h_sel_ext  = 32'(h_sel);
  assign head_nxt   = (head_q == LAST_ADDR) ? '0 : head_q + 1'b1;
  assign tail_nxt   = (tail_q == LAST_ADDR) ? '0 : tail_q + 1'b1;

  assign op_push    = (mode_q == MODE_ACTIVATE) && idx_ok_q && (count_q != CNT_FULL) &&
                      !ent_rd.tracked;
  assign op_restore = (mode_q == MODE_USED) && idx_ok_q && ent_rd.tracked;
  assign rotate     = ent_rd.tracked && (ent_rd.rem_chances != '0);
  assign out_load   = (state_q == ST_RESP) && (!out_valid_q || out_o.ready);

  assign ring_raddr = (state_q == ST_EV_CHK) ? head_nxt : head_q;
  assign ent_raddr  = (state_q == ST_IDLE) ? in_idx_ext[AW-1:0] : h_sel_ext[AW-1:0];

  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = h_ext[AW-1:0];
    ent_wdata  = ent_rd;
    ring_we    = 1'b0;
    ring_waddr = tail_q;
    ring_wdata = h_q;
    unique case (state_q)
      ST_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_q;
        ent_wdata = '0;
      end
      ST_OP: begin
        ent_waddr  = idx_ext[AW-1:0];
        ring_wdata = idx_q;
        ring_we    = op_push;
        if (op_push) begin
          ent_we    = (owner_q != '0);
          ent_wdata = '{tracked: 1'b1, rem_chances: budget, init_chances: budget};
        end else if (op_restore) begin
          ent_we    = 1'b1;
          ent_wdata = '{tracked: 1'b1, rem_chances: ent_rd.init_chances,
                        init_chances: ent_rd.init_chances};
        end
      end
      ST_EV_CHK: begin
        ent_we  = 1'b1;
        ring_we = rotate;
        if (rotate) begin
          ent_wdata.rem_chances = ent_rd.rem_chances - 1'b1;
        end else begin
          ent_wdata.tracked = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.outcome       = out_outcome_q;
  assign out_o.victim_index  = out_victim_q;
  assign out_o.chances_spent = out_spent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      iter_q      <= '0;
      spent_q     <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_ADDR) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_i.valid) begin
            mode_q        <= in_i.mode;
            idx_q         <= in_i.entry_index;
            owner_q       <= in_i.owner_id;
            idx_ok_q      <= (in_idx_ext < 32'(ENTRIES));
            iter_q        <= '0;
            spent_q       <= '0;
            fwd_q         <= 1'b0;
            res_outcome_q <= OUT_DONE;
            res_victim_q  <= '0;
            res_spent_q   <= '0;
            unique case (in_i.mode)
              MODE_ACTIVATE, MODE_USED: state_q <= ST_OP;
              MODE_EVICT: begin
                if (count_q == '0) begin
                  res_outcome_q <= OUT_EMPTY;
                  state_q       <= ST_RESP;
                end else begin
                  state_q <= ST_EV_ENT;
                end
              end
              default: state_q <= ST_RESP;
            endcase
          end
        end
        ST_OP: begin
          if (op_push) begin
            tail_q  <= tail_nxt;
            count_q <= count_q + 1'b1;
          end
          state_q <= ST_RESP;
        end
        ST_EV_ENT: begin
          if (iter_q == ITER_END) begin
            res_outcome_q <= OUT_LIMIT;
            res_victim_q  <= h_sel;
            res_spent_q   <= spent_q;
            state_q       <= ST_RESP;
          end else begin
            h_q     <= h_sel;
            state_q <= ST_EV_CHK;
          end
        end
        ST_EV_CHK: begin
          head_q <= head_nxt;
          if (rotate) begin
            tail_q  <= tail_nxt;
            iter_q  <= iter_q + 1'b1;
            fwd_q   <= (head_nxt == tail_q);
            if (spent_q != SPENT_MAX) begin
              spent_q <= spent_q + 1'b1;
            end
            state_q <= ST_EV_ENT;
          end else begin
            count_q       <= count_q - 1'b1;
            res_outcome_q <= OUT_VICTIM;
            res_victim_q  <= h_q;
            res_spent_q   <= spent_q;
            state_q       <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_load) begin
            out_valid_q   <= 1'b1;
            out_outcome_q <= res_outcome_q;
            out_victim_q  <= res_victim_q;
            out_spent_q   <= res_spent_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `PMCFE_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_FULL)
  `PMCFE_ASSERT_ALWAYS(a_spent_le_iter, clk_i, rst_ni, 32'(spent_q) <= 32'(iter_q))
  `PMCFE_ASSERT_NEXT(a_pop_count, clk_i, rst_ni, state_q == ST_EV_CHK && !rotate,
                     count_q == $past(count_q) - 1'b1)
  `PMCFE_ASSERT_NEXT(a_rotate_count, clk_i, rst_ni, state_q == ST_EV_CHK && rotate,
                     $stable(count_q) && tail_q != $past(tail_q))

endmodule
